>>> sv/aes128_block_decrypt_unit_assert.svh
// Assertion macros used by the decrypt unit module.
`ifndef AES128_BLOCK_DECRYPT_UNIT_ASSERT_SVH
`define AES128_BLOCK_DECRYPT_UNIT_ASSERT_SVH

// Implication that must hold at every clock edge out of reset.
`define AES_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequence is checked in the cycle after the antecedent.
`define AES_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/aesdec_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 decrypt package
// Shared constants, types and the inverse S-box and column-mix functions.
// ----------------------------------------------------------------------------
package aesdec_pkg;

    localparam int NUM_ROUND_KEYS = 11;
    localparam int KEY_IDX_W      = 4;
    localparam int WORD_W         = 64;
    localparam int BLOCK_W        = 128;

    localparam logic OP_KEY    = 1'b0;
    localparam logic OP_CIPHER = 1'b1;

    localparam logic [KEY_IDX_W-1:0] LAST_KEY_IDX = 4'd10;

    // Payload of one input transfer: a key half or a ciphertext half.
    typedef struct packed {
        logic                 opcode;
        logic [KEY_IDX_W-1:0] round_index;
        logic                 half_select;
        logic [WORD_W-1:0]    data_word;
    } key_or_cipher_t;

    // Payload of one output transfer: one plaintext half.
    typedef struct packed {
        logic [WORD_W-1:0] plain_word;
        logic              out_half;
        logic              last;
    } plain_half_t;

    // Control handed from the sequencer to the round datapath.
    typedef struct packed {
        logic load;
        logic first;
        logic full;
        logic final_rnd;
    } round_ctrl_t;

    // Multiply by two in GF(2^8).
    function automatic logic [7:0] xtime(input logic [7:0] a);
        xtime = {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
    endfunction

    // Inverse column mix of one four-byte column.
    function automatic logic [31:0] inv_mix_col(input logic [31:0] c);
        logic [7:0] a [4];
        logic [7:0] x2 [4];
        logic [7:0] x4 [4];
        logic [7:0] x8 [4];
        logic [7:0] m9 [4];
        logic [7:0] mb [4];
        logic [7:0] md [4];
        logic [7:0] me [4];
        for (int i = 0; i < 4; i++)
        begin
            a[i]  = c[31-8*i -: 8];
            x2[i] = xtime(a[i]);
            x4[i] = xtime(x2[i]);
            x8[i] = xtime(x4[i]);
            m9[i] = x8[i] ^ a[i];
            mb[i] = x8[i] ^ x2[i] ^ a[i];
            md[i] = x8[i] ^ x4[i] ^ a[i];
            me[i] = x8[i] ^ x4[i] ^ x2[i];
        end
        inv_mix_col = {me[0] ^ mb[1] ^ md[2] ^ m9[3],
                       m9[0] ^ me[1] ^ mb[2] ^ md[3],
                       md[0] ^ m9[1] ^ me[2] ^ mb[3],
                       mb[0] ^ md[1] ^ m9[2] ^ me[3]};
    endfunction

    // Inverse S-box as a constant table.
    function automatic logic [7:0] inv_sbox(input logic [7:0] x);
        logic [7:0] t [256];
        t = '{
            8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
            8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
            8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
            8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
            8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
            8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
            8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
            8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
            8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
            8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
            8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
            8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
            8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
            8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
            8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
            8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d};
        inv_sbox = t[x];
    endfunction

endpackage

>>> sv/aesdec_stream_if.sv
// ----------------------------------------------------------------------------
// Valid/ready stream interface
// Carries one payload of a given type with a source and a sink modport.
// ----------------------------------------------------------------------------
interface aesdec_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

>>> sv/aesdec_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module aesdec_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 22
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);
    logic [WIDTH-1:0] mem [DEPTH];

    // Storage and registered read.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end
endmodule

>>> sv/aesdec_round.sv
// ----------------------------------------------------------------------------
// AES inverse round datapath
// Holds the 128-bit state and applies one round per enabled cycle.
// ----------------------------------------------------------------------------
module aesdec_round
    import aesdec_pkg::*;
(
    input  logic               clk,
    input  round_ctrl_t        ctrl,
    input  logic [BLOCK_W-1:0] load_block,
    input  logic [BLOCK_W-1:0] round_key,
    output logic [BLOCK_W-1:0] state
);
    logic [BLOCK_W-1:0] state_reg;
    logic [BLOCK_W-1:0] state_next;
    logic [BLOCK_W-1:0] shsub;
    logic [BLOCK_W-1:0] keyed;
    logic [BLOCK_W-1:0] mixed;

    // Inverse shift rows fused with the inverse S-box, then key addition and inverse column mix.
    always_comb
    begin
        for (int r = 0; r < 4; r++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                shsub[BLOCK_W-1-8*(r+4*((c+r)%4)) -: 8] =
                    inv_sbox(state_reg[BLOCK_W-1-8*(r+4*c) -: 8]);
            end
        end
        keyed = shsub ^ round_key;
        for (int c = 0; c < 4; c++)
        begin
            mixed[BLOCK_W-1-32*c -: 32] = inv_mix_col(keyed[BLOCK_W-1-32*c -: 32]);
        end
    end

    // State update selection.
    always_comb
    begin
        priority if (ctrl.load)
        begin
            state_next = load_block;
        end
        else if (ctrl.first)
        begin
            state_next = state_reg ^ round_key;
        end
        else if (ctrl.full)
        begin
            state_next = mixed;
        end
        else if (ctrl.final_rnd)
        begin
            state_next = keyed;
        end
        else
        begin
            state_next = state_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        state_reg <= state_next;
    end

    assign state = state_reg;
endmodule

>>> sv/aes128_block_decrypt_unit.sv
// ----------------------------------------------------------------------------
// AES-128 block decrypt unit
// Inverse cipher with stored round keys and one shared round unit.
// ----------------------------------------------------------------------------
// Channel  Dir  Payload
// in_ch    in   opcode, round_index, half_select, data_word
// out_ch   out  plain_word, out_half, last
//
// Key loads and first halves are taken without leaving the idle state.
// A second ciphertext half starts the decrypt: each of the eleven rounds passes
// through RD0 and RD1 (two key-half reads through the single read port of
// the key RAM) and then RUN, followed by two output transfers, after which
// the input is ready again.
// Reset is asynchronous and active low; the key store is undefined until written.
// Input is not ready while a block is decrypting or its results wait.
module aes128_block_decrypt_unit
    import aesdec_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    aesdec_stream_if.sink   in_ch,
    aesdec_stream_if.source out_ch
);
`include "aes128_block_decrypt_unit_assert.svh"

    localparam int ADDR_W = $clog2(2*NUM_ROUND_KEYS);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_RD0  = 3'd1;
    localparam logic [2:0] S_RD1  = 3'd2;
    localparam logic [2:0] S_RUN  = 3'd3;
    localparam logic [2:0] S_OUT0 = 3'd4;
    localparam logic [2:0] S_OUT1 = 3'd5;

    logic [2:0]            st_reg, st_next;
    logic [KEY_IDX_W-1:0]  rnd_reg, rnd_next;
    logic [WORD_W-1:0]     pend_reg, pend_next;
    logic [WORD_W-1:0]     second_reg;
    logic [WORD_W-1:0]     khi_reg;
    logic                  loaded_reg, loaded_next;
    logic                  wr_en;
    logic [ADDR_W-1:0]     wr_addr, rd_addr;
    logic [WORD_W-1:0]     rd_data;
    logic [BLOCK_W-1:0]    state;
    round_ctrl_t           ctrl;
    logic                  acc_in;

    // Payload unpacking.
    logic                  opcode;
    logic [KEY_IDX_W-1:0]  round_index;
    logic                  half_select;
    logic [WORD_W-1:0]     data_word;
    assign opcode      = in_ch.payload.opcode;
    assign round_index = in_ch.payload.round_index;
    assign half_select = in_ch.payload.half_select;
    assign data_word   = in_ch.payload.data_word;

    assign in_ch.ready = (st_reg == S_IDLE);
    assign acc_in      = in_ch.valid && in_ch.ready;

    // Key RAM: two halves per round key.
    assign wr_en   = acc_in && (opcode == OP_KEY) && (round_index <= LAST_KEY_IDX);
    assign wr_addr = ADDR_W'({round_index, half_select});
    assign rd_addr = ADDR_W'({rnd_reg, (st_reg == S_RD1)});

    aesdec_ram #(.WIDTH(WORD_W), .DEPTH(2*NUM_ROUND_KEYS)) u_keys (
        .clk     (clk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (data_word),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    aesdec_round u_round (
        .clk        (clk),
        .ctrl       (ctrl),
        .load_block ({pend_reg, second_reg}),
        .round_key  ({khi_reg, rd_data}),
        .state      (state)
    );

    // Sequencer: RD0 reads the high key half, RD1 the low half, RUN applies the round.
    always_comb
    begin
        st_next     = st_reg;
        rnd_next    = rnd_reg;
        pend_next   = pend_reg;
        loaded_next = loaded_reg;
        ctrl        = '0;
        unique case (st_reg)
            S_IDLE:
            begin
                if (acc_in && (opcode == OP_CIPHER))
                begin
                    if (!half_select)
                    begin
                        pend_next = data_word;
                    end
                    else
                    begin
                        rnd_next    = LAST_KEY_IDX;
                        loaded_next = 1'b0;
                        st_next     = S_RD0;
                    end
                end
            end
            S_RD0:
            begin
                ctrl.load   = !loaded_reg;
                loaded_next = 1'b1;
                st_next     = S_RD1;
            end
            S_RD1:
            begin
                st_next = S_RUN;
            end
            S_RUN:
            begin
                ctrl.first     = (rnd_reg == LAST_KEY_IDX);
                ctrl.final_rnd = (rnd_reg == '0);
                ctrl.full      = !ctrl.first && !ctrl.final_rnd;
                if (rnd_reg == '0)
                begin
                    st_next = S_OUT0;
                end
                else
                begin
                    rnd_next = rnd_reg - 1'b1;
                    st_next  = S_RD0;
                end
            end
            S_OUT0:
            begin
                if (out_ch.ready)
                begin
                    st_next = S_OUT1;
                end
            end
            S_OUT1:
            begin
                if (out_ch.ready)
                begin
                    st_next = S_IDLE;
                end
            end
            default:
            begin
                st_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= S_IDLE;
            rnd_reg    <= '0;
            pend_reg   <= '0;
            loaded_reg <= 1'b0;
        end
        else
        begin
            st_reg     <= st_next;
            rnd_reg    <= rnd_next;
            pend_reg   <= pend_next;
            loaded_reg <= loaded_next;
        end
    end

    // Payload capture: second half and the latched high key word.
    always_ff @(posedge clk)
    begin
        if (acc_in)
        begin
            second_reg <= data_word;
        end
        if (st_reg == S_RD1)
        begin
            khi_reg <= rd_data;
        end
    end

    // Output transfers.
    assign out_ch.valid              = (st_reg == S_OUT0) || (st_reg == S_OUT1);
    assign out_ch.payload.plain_word = (st_reg == S_OUT1) ? state[WORD_W-1:0]
                                                          : state[BLOCK_W-1:WORD_W];
    assign out_ch.payload.out_half   = (st_reg == S_OUT1);
    assign out_ch.payload.last       = (st_reg == S_OUT1);

    `AES_ASSERT_IMP(a_no_in_busy, clk, rst_n, st_reg != S_IDLE, !in_ch.ready, "busy but ready")
    `AES_ASSERT_NEXT(a_out_seq, clk, rst_n, (st_reg == S_OUT0) && out_ch.ready, st_reg == S_OUT1, "half order")
    `AES_ASSERT_NEXT(a_run_to_out, clk, rst_n, (st_reg == S_RUN) && (rnd_reg == '0), st_reg == S_OUT0, "final round")
endmodule
